// ===== rtl/fml_pkg.sv =====
// Fundamental loop matrix package: transaction payload types and status codes.
// No dependencies; imported by every module of the block.
package fml_pkg;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_CAP = 2'd2;

    localparam int PORT_LABEL_BITS = 16;

    typedef struct packed {
        logic [15:0] from_node;
        logic [15:0] to_node;
        logic        last_branch;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  loop_index;
        logic [31:0] plus_mask;
        logic [31:0] minus_mask;
        logic [4:0]  node_count;
        logic [5:0]  loop_count;
        logic        has_loop;
        logic [1:0]  status;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic sub;
        logic ovf;
    } t_alu_ctl;

endpackage

// ===== rtl/fml_row_alu.sv =====
// Signed row combiner: adds or subtracts two rows of {-1,0,+1} entries.
// Each row is a plus mask and a minus mask. Depends on fml_pkg.
module fml_row_alu
    import fml_pkg::*;
#(
    parameter int W = 32
) (
    input  logic [W-1:0] i_a_p,
    input  logic [W-1:0] i_a_m,
    input  logic [W-1:0] i_b_p,
    input  logic [W-1:0] i_b_m,
    input  logic         i_sub,
    output logic [W-1:0] o_r_p,
    output logic [W-1:0] o_r_m,
    output logic         o_ovf
);

    logic [W-1:0] w_bp;
    logic [W-1:0] w_bm;
    t_alu_ctl     w_ctl;

    always_comb begin
        w_ctl.sub = i_sub;
        // subtraction swaps the signs of the second row
        w_bp      = w_ctl.sub ? i_b_m : i_b_p;
        w_bm      = w_ctl.sub ? i_b_p : i_b_m;
        w_ctl.ovf = |((i_a_p & w_bp) | (i_a_m & w_bm));
        o_r_p     = (i_a_p & ~w_bp & ~w_bm) | (w_bp & ~i_a_p & ~i_a_m);
        o_r_m     = (i_a_m & ~w_bp & ~w_bm) | (w_bm & ~i_a_p & ~i_a_m);
        o_ovf     = w_ctl.ovf;
    end

endmodule

// ===== rtl/fundamental_loop_matrix_unit.sv =====
// Fundamental loop matrix unit: top level with sequencer, label table and row store.
// Depends on fml_pkg and fml_row_alu.
//
// Usage: branches arrive on the input channel (valid/ready), one transaction per
// branch. The transaction with last_branch set closes the run: the unit then
// dedupes the node labels (one compare a cycle), ranks them, builds one incidence
// row a cycle, and eliminates column by column with the shared row combiner: a
// pivot search per column and, where one is found, an update of the other rows.
// Each loop row is then assembled in turn. Input ready is low from the closing
// branch until the last result of the run has been taken.
// Results appear on the output channel from a holding register; a stalled
// receiver simply holds the unit in its output state with the payload steady.
// Error runs and tree-only runs give a single result with last_result set.
// Reset (synchronous, active low) empties the branch and label stores; the
// same happens after the final result of each run, so a new run starts at once.
module fundamental_loop_matrix_unit
    import fml_pkg::*;
#(
    parameter int MAX_BRANCHES = 32,
    parameter int MAX_NODES    = 32,
    parameter int LABEL_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int MB  = MAX_BRANCHES;
    localparam int MN  = MAX_NODES;
    localparam int LW  = (LABEL_BITS < PORT_LABEL_BITS) ? LABEL_BITS : PORT_LABEL_BITS;
    localparam int BW  = $clog2(MB);
    localparam int CW  = $clog2(MB + 1);
    localparam int NW  = $clog2(MN);
    localparam int LCW = $clog2(MN + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INS   = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_RKSET = 4'd3;
    localparam logic [3:0] S_RKCNT = 4'd4;
    localparam logic [3:0] S_BUILD = 4'd5;
    localparam logic [3:0] S_PSRCH = 4'd6;
    localparam logic [3:0] S_ELIM  = 4'd7;
    localparam logic [3:0] S_OSET  = 4'd8;
    localparam logic [3:0] S_OSCAN = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]     r_state;
    logic [LW-1:0]  r_from [MB];
    logic [LW-1:0]  r_to   [MB];
    logic [NW-1:0]  r_fidx [MB];
    logic [NW-1:0]  r_tidx [MB];
    logic [NW-1:0]  r_frk  [MB];
    logic [NW-1:0]  r_trk  [MB];
    logic [LW-1:0]  r_lab  [MN];
    logic [MB-1:0]  r_rp   [MN];
    logic [MB-1:0]  r_rm   [MN];
    logic [BW-1:0]  r_pcol [MN];
    logic [CW-1:0]  r_bcnt;
    logic [LCW-1:0] r_lcnt;
    logic [LCW-1:0] r_n;
    logic [1:0]     r_err;
    logic [CW-1:0]  r_j;
    logic           r_side;
    logic [LCW-1:0] r_v;
    logic [LCW-1:0] r_u;
    logic [LCW-1:0] r_k;
    logic [NW-1:0]  r_rk;
    logic [LW-1:0]  r_labu;
    logic [MN-1:0]  r_used;
    logic [MB-1:0]  r_piv_p;
    logic [MB-1:0]  r_piv_m;
    logic           r_vpos;
    logic [NW-1:0]  r_pi;
    logic [MB-1:0]  r_cmask;
    logic [CW-1:0]  r_ccnt;
    logic [CW-1:0]  r_li;
    logic [BW-1:0]  r_c;
    logic [MB-1:0]  r_pl;
    logic [MB-1:0]  r_mi;
    logic           r_ov;
    t_out_item      r_out;

    logic [BW-1:0]  w_jb;
    logic [NW-1:0]  w_kk;
    logic [LW-1:0]  w_key;
    logic           w_less;
    logic [NW-1:0]  w_rank;
    logic [NW-1:0]  w_tgt;
    logic [MB-1:0]  w_bp;
    logic [MB-1:0]  w_bm;
    logic [MB-1:0]  w_rp;
    logic [MB-1:0]  w_rm;
    logic [MB-1:0]  w_ap;
    logic [MB-1:0]  w_am;
    logic           w_ovf;
    logic           w_sub;
    logic [BW-1:0]  w_c;
    logic [BW-1:0]  w_t;

    function automatic t_out_item f_err(input logic [1:0] st);
        t_out_item res;
        res             = '0;
        res.status      = st;
        res.last_result = 1'b1;
        return res;
    endfunction

    function automatic t_out_item f_row(input logic [4:0]  idx,
                                        input logic [31:0] pm,
                                        input logic [31:0] mm,
                                        input logic [4:0]  nodes,
                                        input logic [5:0]  loops,
                                        input logic        has,
                                        input logic        last);
        t_out_item res;
        res             = '0;
        res.loop_index  = idx;
        res.plus_mask   = pm;
        res.minus_mask  = mm;
        res.node_count  = nodes;
        res.loop_count  = loops;
        res.has_loop    = has;
        res.status      = ST_OK;
        res.last_result = last;
        return res;
    endfunction

    assign w_jb   = r_j[BW-1:0];
    assign w_kk   = r_k[NW-1:0];
    assign w_key  = r_side ? r_to[w_jb] : r_from[w_jb];
    assign w_less = r_lab[r_v[NW-1:0]] < r_labu;
    assign w_rank = r_rk + NW'(w_less);
    assign w_tgt  = NW'(r_k + 1'b1);
    assign w_rp   = r_rp[w_kk];
    assign w_rm   = r_rm[w_kk];
    assign w_sub  = (w_rp[w_jb] == r_vpos);
    assign w_t    = r_pcol[w_kk];

    // incidence row for rank w_tgt; the to end wins on a self-loop
    always_comb begin
        for (int b = 0; b < MB; b++) begin
            w_bp[b] = (CW'(b) < r_bcnt) && (r_trk[b] == w_tgt);
            w_bm[b] = (CW'(b) < r_bcnt) && (r_frk[b] == w_tgt) && !w_bp[b];
        end
    end

    // lowest remaining cotree column
    always_comb begin
        w_c = '0;
        for (int b = MB - 1; b >= 0; b--) begin
            if (r_cmask[b]) begin
                w_c = BW'(b);
            end
        end
    end

    fml_row_alu #(
        .W (MB)
    ) u_alu (
        .i_a_p (w_rp),
        .i_a_m (w_rm),
        .i_b_p (r_piv_p),
        .i_b_m (r_piv_m),
        .i_sub (w_sub),
        .o_r_p (w_ap),
        .o_r_m (w_am),
        .o_ovf (w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_bcnt  <= '0;
            r_lcnt  <= '0;
            r_err   <= ST_OK;
            r_used  <= '0;
            r_cmask <= '0;
            r_ccnt  <= '0;
            r_li    <= '0;
            r_ov    <= 1'b0;
            r_j     <= '0;
            r_k     <= '0;
            r_v     <= '0;
            r_u     <= '0;
            r_side  <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        if (r_bcnt < CW'(MB)) begin
                            r_from[r_bcnt[BW-1:0]] <= i_in_data.from_node[LW-1:0];
                            r_to[r_bcnt[BW-1:0]]   <= i_in_data.to_node[LW-1:0];
                            r_bcnt <= r_bcnt + 1'b1;
                        end else begin
                            r_err <= ST_CAP;
                        end
                        if (i_in_data.last_branch) begin
                            if (r_err != ST_OK || r_bcnt == CW'(MB)) begin
                                r_out   <= f_err(ST_CAP);
                                r_ov    <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_j     <= '0;
                                r_side  <= 1'b0;
                                r_v     <= '0;
                                r_state <= S_INS;
                            end
                        end
                    end
                end
                S_INS: begin
                    if (r_v != r_lcnt) begin
                        if (r_lab[r_v[NW-1:0]] == w_key) begin
                            if (r_side) r_tidx[w_jb] <= r_v[NW-1:0];
                            else r_fidx[w_jb] <= r_v[NW-1:0];
                            r_v    <= '0;
                            r_side <= !r_side;
                            if (r_side) begin
                                if (r_j == r_bcnt - 1'b1) r_state <= S_CHK;
                                else r_j <= r_j + 1'b1;
                            end
                        end else begin
                            r_v <= r_v + 1'b1;
                        end
                    end else if (r_lcnt == LCW'(MN)) begin
                        r_out   <= f_err(ST_CAP);
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_lab[r_lcnt[NW-1:0]] <= w_key;
                        if (r_side) r_tidx[w_jb] <= r_lcnt[NW-1:0];
                        else r_fidx[w_jb] <= r_lcnt[NW-1:0];
                        r_lcnt <= r_lcnt + 1'b1;
                        r_v    <= '0;
                        r_side <= !r_side;
                        if (r_side) begin
                            if (r_j == r_bcnt - 1'b1) r_state <= S_CHK;
                            else r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    r_n <= r_lcnt - 1'b1;
                    r_u <= '0;
                    if (int'(r_lcnt) - 1 > int'(r_bcnt)) begin
                        r_out   <= f_err(ST_BAD);
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RKSET;
                    end
                end
                S_RKSET: begin
                    r_labu  <= r_lab[r_u[NW-1:0]];
                    r_rk    <= '0;
                    r_v     <= '0;
                    r_state <= S_RKCNT;
                end
                S_RKCNT: begin
                    if (r_v == r_lcnt - 1'b1) begin
                        for (int b = 0; b < MB; b++) begin
                            if (r_fidx[b] == r_u[NW-1:0]) r_frk[b] <= w_rank;
                            if (r_tidx[b] == r_u[NW-1:0]) r_trk[b] <= w_rank;
                        end
                        if (r_u == r_lcnt - 1'b1) begin
                            r_k     <= '0;
                            r_state <= S_BUILD;
                        end else begin
                            r_u     <= r_u + 1'b1;
                            r_state <= S_RKSET;
                        end
                    end else begin
                        r_rk <= w_rank;
                        r_v  <= r_v + 1'b1;
                    end
                end
                S_BUILD: begin
                    if (r_k == r_n) begin
                        r_k     <= '0;
                        r_j     <= '0;
                        r_state <= S_PSRCH;
                    end else begin
                        r_rp[w_kk] <= w_bp;
                        r_rm[w_kk] <= w_bm;
                        r_k        <= r_k + 1'b1;
                    end
                end
                S_PSRCH: begin
                    if (r_k == r_n) begin
                        // no pivot: cotree column
                        if (int'(r_ccnt) + int'(r_n) >= int'(r_bcnt)) begin
                            r_out   <= f_err(ST_BAD);
                            r_ov    <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_cmask[w_jb] <= 1'b1;
                            r_ccnt        <= r_ccnt + 1'b1;
                            r_k           <= '0;
                            if (r_j == r_bcnt - 1'b1) r_state <= S_OSET;
                            else r_j <= r_j + 1'b1;
                        end
                    end else if (!r_used[w_kk] && (w_rp[w_jb] || w_rm[w_jb])) begin
                        r_piv_p      <= w_rp;
                        r_piv_m      <= w_rm;
                        r_vpos       <= w_rp[w_jb];
                        r_pi         <= w_kk;
                        r_used[w_kk] <= 1'b1;
                        r_pcol[w_kk] <= w_jb;
                        r_k          <= '0;
                        r_state      <= S_ELIM;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_ELIM: begin
                    if (w_kk != r_pi && (w_rp[w_jb] || w_rm[w_jb]) && w_ovf) begin
                        r_out   <= f_err(ST_BAD);
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        if (w_kk != r_pi && (w_rp[w_jb] || w_rm[w_jb])) begin
                            r_rp[w_kk] <= w_ap;
                            r_rm[w_kk] <= w_am;
                        end
                        if (r_k == r_n - 1'b1) begin
                            r_k <= '0;
                            if (r_j == r_bcnt - 1'b1) begin
                                r_state <= S_OSET;
                            end else begin
                                r_j     <= r_j + 1'b1;
                                r_state <= S_PSRCH;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_OSET: begin
                    if (r_ccnt == '0) begin
                        r_out   <= f_row(5'd0, 32'd0, 32'd0, 5'(r_n), 6'd0, 1'b0, 1'b1);
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_c     <= w_c;
                        r_pl    <= MB'(1) << w_c;
                        r_mi    <= '0;
                        r_k     <= '0;
                        r_state <= S_OSCAN;
                    end
                end
                S_OSCAN: begin
                    if (r_k == r_n) begin
                        r_out        <= f_row(5'(r_li), 32'(r_pl), 32'(r_mi), 5'(r_n),
                                              6'(r_ccnt), 1'b1, (r_li + 1'b1 == r_ccnt));
                        r_cmask[r_c] <= 1'b0;
                        r_ov         <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        // a tree column is nonzero only in its pivot row
                        if (r_used[w_kk] && (w_rp[r_c] || w_rm[r_c])) begin
                            if (w_rp[r_c] == w_rp[w_t]) r_mi[w_t] <= 1'b1;
                            else r_pl[w_t] <= 1'b1;
                        end
                        r_k <= r_k + 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_ov <= 1'b0;
                        if (r_out.last_result) begin
                            r_bcnt  <= '0;
                            r_lcnt  <= '0;
                            r_err   <= ST_OK;
                            r_used  <= '0;
                            r_cmask <= '0;
                            r_ccnt  <= '0;
                            r_li    <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_li    <= r_li + 1'b1;
                            r_state <= S_OSET;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input taken while a result is pending");

    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_result)
        |=> (o_in_ready && r_bcnt == '0 && r_lcnt == '0))
        else $error("run state not cleared after final result");

    a_cotree_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccnt <= r_bcnt)
        else $error("more cotree columns than branches");

    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_lcnt) <= MN)
        else $error("label table overrun");

endmodule
